>>> rtl/ffrl_pkg.sv
// Shared types, constants and register codes for the feed-forward torque ramp limiter.
package ffrl_pkg;

  localparam int AxisFields = 6;
  localparam int AxisCount  = 6;
  localparam int AxisUsed   = (AxisCount < AxisFields) ? AxisCount : AxisFields;
  localparam int JointField = 15;
  localparam int JointCount = 15;
  localparam int JointUsed  = (JointCount < JointField) ? JointCount : JointField;

  localparam int TorqueW = 16;
  localparam int LimitW  = 15;
  localparam int RampW   = 16;
  localparam int SignsW  = 2 * AxisFields;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  localparam int InDataW  = 128;
  localparam int OutDataW = 120;

  // Bit offsets inside the stream words
  localparam int InDrvLsb    = 1;
  localparam int InHomedLsb  = 7;
  localparam int InJointLsb  = 13;
  localparam int InTorqueLsb = 28;
  localparam int OutRampLsb  = 1;
  localparam int OutDrvLsb   = 17;

  localparam logic [RampW:0]  RampOne   = 17'd32768;
  localparam logic [RampW:0]  RoundHalf = 17'd16384;

  localparam logic [AxisFields-1:0][LimitW-1:0] LimitReset = {
    15'd384, 15'd384, 15'd512, 15'd1587, 15'd2432, 15'd1690
  };
  localparam logic [SignsW-1:0] SignsReset = 12'd3572;
  localparam logic [RampW-1:0]  StepReset  = 16'd164;

  typedef enum logic [CfgIdxW-1:0] {
    RegLimit0   = 3'd0,
    RegLimit1   = 3'd1,
    RegLimit2   = 3'd2,
    RegLimit3   = 3'd3,
    RegLimit4   = 3'd4,
    RegLimit5   = 3'd5,
    RegSigns    = 3'd6,
    RegRampStep = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SignZero  = 2'd0,
    SignPlus  = 2'd1,
    SignMinus = 2'd3
  } sign_code_e;

  typedef struct packed {
    logic [AxisFields-1:0][LimitW-1:0] limit;
    logic [SignsW-1:0]                 signs;
    logic [RampW-1:0]                  ramp_step;
  } cfg_t;

  typedef struct packed {
    logic                               ff_enable;
    logic [AxisFields-1:0]              drives_on_mask;
    logic [AxisFields-1:0]              homed_mask;
    logic [JointField-1:0]              joint_moving_mask;
    logic [AxisFields-1:0][TorqueW-1:0] ff_torque;
  } in_item_t;

  typedef struct packed {
    logic                              active;
    logic [RampW-1:0]                  ramp;
    logic [AxisFields-1:0][LimitW-1:0] mag;
    logic [AxisFields-1:0]             neg;
    logic [AxisFields-1:0]             zero;
  } mid_t;

  typedef struct packed {
    logic                               ff_active;
    logic [RampW-1:0]                   ramp_level;
    logic [AxisFields-1:0][TorqueW-1:0] drive_torque;
  } out_item_t;

endpackage

>>> rtl/ffrl_cfg_regs.sv
// Configuration register file: torque limits, axis sign codes and ramp step.
module ffrl_cfg_regs import ffrl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic [CfgIdxW-1:0] index_i,
  input  logic [CfgDatW-1:0] data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (cfg_reg_e'(index_i))
        RegLimit0:   cfg_d.limit[0]   = data_i[LimitW-1:0];
        RegLimit1:   cfg_d.limit[1]   = data_i[LimitW-1:0];
        RegLimit2:   cfg_d.limit[2]   = data_i[LimitW-1:0];
        RegLimit3:   cfg_d.limit[3]   = data_i[LimitW-1:0];
        RegLimit4:   cfg_d.limit[4]   = data_i[LimitW-1:0];
        RegLimit5:   cfg_d.limit[5]   = data_i[LimitW-1:0];
        RegSigns:    cfg_d.signs      = data_i[SignsW-1:0];
        RegRampStep: cfg_d.ramp_step  = data_i[RampW-1:0];
        default:     cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit     <= LimitReset;
      cfg_q.signs     <= SignsReset;
      cfg_q.ramp_step <= StepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/ffrl_limit.sv
// Activation latch, ramp state, zero-hold and clamp per axis; registers the limited word.
module ffrl_limit import ffrl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output mid_t     mid_o
);

  logic                        motion_q, motion_d;
  logic [RampW-1:0]            ramp_q, ramp_d;
  logic [TorqueW-1:0]          held_q [AxisFields];
  logic [TorqueW-1:0]          held_d [AxisFields];
  mid_t                        mid_q, mid_d;

  logic                        ready;
  logic                        moving;
  logic                        gate;
  logic [RampW:0]              ramp_sum;
  logic signed [TorqueW:0]     tv    [AxisFields];
  logic signed [TorqueW:0]     lim   [AxisFields];
  logic signed [TorqueW:0]     clamp [AxisFields];
  logic signed [TorqueW:0]     absv  [AxisFields];
  logic [1:0]                  code  [AxisFields];

  always_comb begin
    ready    = (&item_i.drives_on_mask[AxisUsed-1:0]) & (&item_i.homed_mask[AxisUsed-1:0]);
    moving   = |item_i.joint_moving_mask[JointUsed-1:0];
    gate     = item_i.ff_enable & ready;
    motion_d = gate & (motion_q | moving);

    // sum kept one bit wider so it saturates instead of wrapping
    ramp_sum = {1'b0, ramp_q} + {1'b0, cfg_i.ramp_step};
    if (!motion_d) begin
      ramp_d = '0;
    end else if (ramp_sum > RampOne) begin
      ramp_d = RampOne[RampW-1:0];
    end else begin
      ramp_d = ramp_sum[RampW-1:0];
    end

    mid_d.active = motion_d;
    mid_d.ramp   = ramp_d;

    for (int i = 0; i < AxisFields; i++) begin
      tv[i] = {item_i.ff_torque[i][TorqueW-1], item_i.ff_torque[i]};
      // zero from the planner means "keep last torque" on all but the first axis
      if (i != 0 && held_q[i] != '0 && tv[i] == '0) begin
        tv[i] = {held_q[i][TorqueW-1], held_q[i]};
      end
      lim[i] = {2'b00, cfg_i.limit[i]};
      if (tv[i] > lim[i]) begin
        clamp[i] = lim[i];
      end else if (tv[i] < -lim[i]) begin
        clamp[i] = -lim[i];
      end else begin
        clamp[i] = tv[i];
      end
      absv[i]  = clamp[i][TorqueW] ? -clamp[i] : clamp[i];
      code[i]  = cfg_i.signs[2*i +: 2];

      mid_d.mag[i]  = absv[i][LimitW-1:0];
      mid_d.neg[i]  = clamp[i][TorqueW] ^ (code[i] == SignMinus);
      mid_d.zero[i] = !(motion_d && (i < AxisUsed) &&
                        (code[i] == SignPlus || code[i] == SignMinus));
      held_d[i] = (motion_d && (i < AxisUsed)) ? clamp[i][TorqueW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q <= 1'b0;
      ramp_q   <= '0;
      for (int i = 0; i < AxisFields; i++) begin
        held_q[i] <= '0;
      end
    end else if (step_i) begin
      motion_q <= motion_d;
      ramp_q   <= ramp_d;
      for (int i = 0; i < AxisFields; i++) begin
        held_q[i] <= held_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

>>> rtl/ffrl_scale.sv
// Ramp scaling per axis: one multiply, round half away from zero, sign apply.
module ffrl_scale import ffrl_pkg::*; (
  input  logic      clk_i,
  input  logic      load_i,
  input  mid_t      mid_i,
  output out_item_t out_o
);

  out_item_t            out_q, out_d;
  logic [31:0]          prod [AxisFields];
  logic [TorqueW-1:0]   q    [AxisFields];

  always_comb begin
    out_d.ff_active  = mid_i.active;
    out_d.ramp_level = mid_i.ramp;
    for (int i = 0; i < AxisFields; i++) begin
      // magnitude is at most 32767, so the rounded quotient fits 15 bits
      prod[i] = 32'(mid_i.mag[i]) * 32'(mid_i.ramp) + 32'(RoundHalf);
      q[i]    = prod[i][30:15];
      if (mid_i.zero[i]) begin
        out_d.drive_torque[i] = '0;
      end else if (mid_i.neg[i]) begin
        out_d.drive_torque[i] = -q[i];
      end else begin
        out_d.drive_torque[i] = q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

>>> rtl/feedforward_torque_ramp_limiter_core.sv
// A word accepted on the slave side passes the input register, the clamp stage and
// the scale stage in turn. Throughput: one word per cycle; every stage holds
// independently under backpressure. Ramp, motion latch and held torques update as a
// word enters the clamp stage, so the next word sees them without a bubble.
// Reset (rst_ni low, async): pipeline empty, ramp and held torques zero, registers
// back to their default limits, sign codes and ramp step.
module feedforward_torque_ramp_limiter_core import ffrl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // lsb up: ff_enable, drives_on_mask, homed_mask, joint_moving_mask,
  // ff_torque_0..ff_torque_5, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // lsb up: ff_active, ramp_level, drive_torque_0..drive_torque_5, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q, in_d;
  mid_t      mid;
  out_item_t out_w;

  logic v0_q, v0_d, v1_q, v1_d, v2_q, v2_d;
  logic rdy0, rdy1, rdy2;
  logic take, step, load;

  assign cfg_ready_o = 1'b1;

  ffrl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  always_comb begin
    rdy2 = !v2_q | m_axis_tready;
    rdy1 = !v1_q | rdy2;
    rdy0 = !v0_q | rdy1;
    take = s_axis_tvalid & rdy0;
    step = v0_q & rdy1;
    load = v1_q & rdy2;
    v0_d = take | (v0_q & !rdy1);
    v1_d = step | (v1_q & !rdy2);
    v2_d = load | (v2_q & !m_axis_tready);
  end

  assign s_axis_tready = rdy0;

  always_comb begin
    in_d.ff_enable         = s_axis_tdata[0];
    in_d.drives_on_mask    = s_axis_tdata[InDrvLsb +: AxisFields];
    in_d.homed_mask        = s_axis_tdata[InHomedLsb +: AxisFields];
    in_d.joint_moving_mask = s_axis_tdata[InJointLsb +: JointField];
    for (int i = 0; i < AxisFields; i++) begin
      in_d.ff_torque[i] = s_axis_tdata[InTorqueLsb + TorqueW*i +: TorqueW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_d;
    end
  end

  ffrl_limit u_limit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .mid_o  (mid)
  );

  ffrl_scale u_scale (
    .clk_i  (clk_i),
    .load_i (load),
    .mid_i  (mid),
    .out_o  (out_w)
  );

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[0]                       = out_w.ff_active;
    m_axis_tdata[OutRampLsb +: RampW]     = out_w.ramp_level;
    for (int i = 0; i < AxisFields; i++) begin
      m_axis_tdata[OutDrvLsb + TorqueW*i +: TorqueW] = out_w.drive_torque[i];
    end
  end

  assign m_axis_tvalid = v2_q;

endmodule

>>> rtl/ffrl_checker.sv
// Port-level checks for the torque ramp limiter, bound to the top level.
module ffrl_checker import ffrl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // ramp is zero whenever the block is inactive
  a_ramp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == 16'd0)
    else $error("ramp nonzero while inactive");

  // no torque reaches the drives while inactive
  a_torque_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[112:17] == 96'd0)
    else $error("drive torque nonzero while inactive");

  // ramp never exceeds one
  a_ramp_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[16] && m_axis_tdata[15:1] != 15'd0))
    else $error("ramp above one");

endmodule

bind feedforward_torque_ramp_limiter_core ffrl_checker u_ffrl_checker (.*);

>>> tb/tb_top.sv
// Self-checking stream testbench for the feed-forward torque ramp limiter core.
`timescale 1ns / 100ps

module tb_top;
  import ffrl_pkg::*;

  localparam int StallLimit = 5000;

  class torque_scoreboard;
    logic [LimitW-1:0] limit_q [AxisFields];
    logic [SignsW-1:0] signs_q;
    logic [RampW-1:0]  step_q;
    bit                motion_latched;
    int                ramp_q;
    int                held_q [AxisFields];
    out_item_t         drive_cmd_q [$];
    int                mismatches;

    function new();
      limit_q = '{15'd1690, 15'd2432, 15'd1587, 15'd512, 15'd384, 15'd384};
      signs_q = 12'd3572;
      step_q = 16'd164;
      motion_latched = 1'b0;
      ramp_q = 0;
      foreach (held_q[i]) held_q[i] = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] value);
      case (cfg_reg_e'(idx))
        RegLimit0, RegLimit1, RegLimit2, RegLimit3, RegLimit4, RegLimit5: begin
          limit_q[idx] = value[LimitW-1:0];
        end
        RegSigns: signs_q = value[SignsW-1:0];
        RegRampStep: step_q = value[RampW-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t predict_tick(in_item_t w);
      out_item_t r;
      bit ready, active;
      int t, lim, mag, q, sq, res, sum;
      logic [1:0] code;
      longint prod;
      ready = (&w.drives_on_mask[AxisUsed-1:0]) && (&w.homed_mask[AxisUsed-1:0]);
      if (w.ff_enable && ready) begin
        if (|w.joint_moving_mask[JointUsed-1:0]) motion_latched = 1'b1;
        active = motion_latched;
      end else begin
        motion_latched = 1'b0;
        active = 1'b0;
      end
      if (active) begin
        sum = ramp_q + int'(step_q);
        ramp_q = (sum > 32768) ? 32768 : sum;
      end else begin
        ramp_q = 0;
      end
      r.ff_active = active;
      r.ramp_level = ramp_q[RampW-1:0];
      for (int i = 0; i < AxisFields; i++) begin
        res = 0;
        if (i < AxisUsed) begin
          t = $signed(w.ff_torque[i]);
          lim = int'(limit_q[i]);
          // axis 0 never reuses its last torque
          if (i != 0 && held_q[i] != 0 && t == 0) t = held_q[i];
          if (t > lim) t = lim;
          else if (t < -lim) t = -lim;
          if (active) begin
            code = signs_q[2*i +: 2];
            mag = (t < 0) ? -t : t;
            prod = longint'(mag) * longint'(ramp_q) + 64'd16384;
            q = int'(prod >>> 15);
            sq = (t < 0) ? -q : q;
            if (code == SignPlus) res = sq;
            else if (code == SignMinus) res = -sq;
            held_q[i] = t;
          end else begin
            held_q[i] = 0;
          end
        end
        r.drive_torque[i] = res[TorqueW-1:0];
      end
      return r;
    endfunction

    function void note_tick(in_item_t w);
      drive_cmd_q.push_back(predict_tick(w));
    endfunction

    function void flag(string what, logic [TorqueW-1:0] exp_v, logic [TorqueW-1:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_w;
      if (drive_cmd_q.size() == 0) begin
        flag("word with nothing pending", '0, got.ramp_level);
        return;
      end
      exp_w = drive_cmd_q.pop_front();
      if (got.ff_active !== exp_w.ff_active)
        flag("ff_active", 16'(exp_w.ff_active), 16'(got.ff_active));
      if (got.ramp_level !== exp_w.ramp_level)
        flag("ramp_level", exp_w.ramp_level, got.ramp_level);
      for (int i = 0; i < AxisFields; i++)
        if (got.drive_torque[i] !== exp_w.drive_torque[i])
          flag($sformatf("drive_torque_%0d", i), exp_w.drive_torque[i], got.drive_torque[i]);
    endfunction

    function int pending();
      return drive_cmd_q.size();
    endfunction

    function void close_out();
      if (drive_cmd_q.size() != 0) flag("words never returned", '0, 16'(drive_cmd_q.size()));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold = 0;
  int quiet_cycles = 0;

  torque_scoreboard sb = new();

  feedforward_torque_ramp_limiter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [InDataW-1:0] pack_tick(in_item_t w);
    logic [InDataW-1:0] d;
    d = '0;
    d[0] = w.ff_enable;
    d[InDrvLsb +: AxisFields] = w.drives_on_mask;
    d[InHomedLsb +: AxisFields] = w.homed_mask;
    d[InJointLsb +: JointField] = w.joint_moving_mask;
    for (int i = 0; i < AxisFields; i++) d[InTorqueLsb + TorqueW*i +: TorqueW] = w.ff_torque[i];
    return d;
  endfunction

  function automatic out_item_t unpack_cmd(logic [OutDataW-1:0] d);
    out_item_t r;
    r.ff_active = d[0];
    r.ramp_level = d[OutRampLsb +: RampW];
    for (int i = 0; i < AxisFields; i++) r.drive_torque[i] = d[OutDrvLsb + TorqueW*i +: TorqueW];
    return r;
  endfunction

  function automatic in_item_t pack_to_item(logic [InDataW-1:0] d);
    in_item_t w;
    w.ff_enable = d[0];
    w.drives_on_mask = d[InDrvLsb +: AxisFields];
    w.homed_mask = d[InHomedLsb +: AxisFields];
    w.joint_moving_mask = d[InJointLsb +: JointField];
    for (int i = 0; i < AxisFields; i++) w.ff_torque[i] = d[InTorqueLsb + TorqueW*i +: TorqueW];
    return w;
  endfunction

  // monitors sample pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(pack_to_item(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_result(unpack_cmd(m_axis_tdata));
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (recv_hold > 0) begin
        m_axis_tready <= 1'b0;
        recv_hold = recv_hold - 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_tick(input in_item_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tdata <= pack_tick(w);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDatW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // unused upper data bits get random values; the block must drop them
  task automatic load_setting(input logic [AxisFields-1:0][LimitW-1:0] lims,
                              input logic [SignsW-1:0] signs, input logic [RampW-1:0] step);
    for (int i = 0; i < AxisFields; i++)
      write_reg(cfg_reg_e'(i), {1'($urandom_range(1)), lims[i]});
    write_reg(RegSigns, {4'($urandom_range(15)), signs});
    write_reg(RegRampStep, step);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t mk_tick(logic en, logic [AxisFields-1:0] drv,
                                       logic [AxisFields-1:0] hom, logic [JointField-1:0] joint,
                                       logic [AxisFields-1:0][TorqueW-1:0] tq);
    in_item_t w;
    w.ff_enable = en;
    w.drives_on_mask = drv;
    w.homed_mask = hom;
    w.joint_moving_mask = joint;
    w.ff_torque = tq;
    return w;
  endfunction

  function automatic logic [TorqueW-1:0] rand_torque();
    int v;
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      4, 5, 6: begin
        v = $urandom_range(4096);
        return 16'(v - 2048);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed ticks keep enable and readiness up so the ramp gets going
  function automatic in_item_t rand_tick(bit well_formed);
    in_item_t w;
    w.ff_enable = well_formed ? ($urandom_range(99) >= 2) : 1'($urandom_range(1));
    w.drives_on_mask = (well_formed && $urandom_range(99) >= 2) ? '1 : 6'($urandom_range(63));
    w.homed_mask = (well_formed && $urandom_range(99) >= 2) ? '1 : 6'($urandom_range(63));
    case ($urandom_range(4))
      0, 1: w.joint_moving_mask = '0;
      2: w.joint_moving_mask = 15'(1 << $urandom_range(JointField - 1));
      default: w.joint_moving_mask = 15'($urandom_range(32767));
    endcase
    for (int i = 0; i < AxisFields; i++) w.ff_torque[i] = rand_torque();
    return w;
  endfunction

  function automatic logic [AxisFields-1:0][LimitW-1:0] rand_limits();
    logic [AxisFields-1:0][LimitW-1:0] l;
    for (int i = 0; i < AxisFields; i++)
      l[i] = ($urandom_range(1) == 1) ? 15'($urandom_range(32767)) : 15'($urandom_range(3000));
    return l;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_tick(rand_tick($urandom_range(99) < 85));
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: latch, hold-over of zero torques, readiness drops
    send_tick(mk_tick(1'b0, '0, '0, '0, '0));
    send_tick(mk_tick(1'b1, '1, '1, '0, {3{16'h8000, 16'h7FFF}}));
    send_tick(mk_tick(1'b1, '1, '1, 15'h4000, {3{16'h8000, 16'h7FFF}}));
    send_tick(mk_tick(1'b1, '1, '1, '0, '0));
    send_tick(mk_tick(1'b1, '1, '1, 15'h0001, {3{16'hFF9C, 16'h0064}}));
    send_tick(mk_tick(1'b1, '1, '1, 15'h7FFF, '0));
    send_tick(mk_tick(1'b1, 6'h3E, '1, 15'h7FFF, {3{16'h0200, 16'hFE00}}));
    send_tick(mk_tick(1'b1, '1, '1, '0, {3{16'h0200, 16'hFE00}}));
    send_tick(mk_tick(1'b1, '1, '1, 15'h0100, '0));
    send_tick(mk_tick(1'b1, '1, 6'h1F, 15'h0100, {3{16'h0180, 16'hFE80}}));
    send_tick(mk_tick(1'b1, '1, '1, 15'h0002, {3{16'h0180, 16'hFE80}}));
    send_tick(mk_tick(1'b0, '1, '1, 15'h7FFF, {3{16'h0180, 16'hFE80}}));
    send_tick(mk_tick(1'b1, '1, '1, 15'h7FFF, {3{16'h0001, 16'hFFFF}}));
    send_tick(mk_tick(1'b1, '1, '1, '0, {16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000,
                                         16'h0000}));
    send_tick(mk_tick(1'b1, '1, '1, '0, '0));
    s_axis_tvalid <= 1'b0;
    drain();

    // widest limits, full-scale step, a mix of sign codes including the unused one
    load_setting({AxisFields{15'h7FFF}}, 12'hD39, 16'h8000);
    run_random(270);
    drain();

    // narrowest limits, zero step
    send_idle_pct = 86;
    load_setting('0, 12'hFFF, 16'h0000);
    run_random(270);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 86;
    load_setting(rand_limits(), 12'($urandom_range(4095)), 16'($urandom_range(6000, 200)));
    run_random(270);
    drain();

    // receiver holds off while the sender keeps offering words
    send_idle_pct = 21;
    recv_stall_pct = 21;
    load_setting(rand_limits(), 12'($urandom_range(4095)), 16'($urandom_range(32768, 1)));
    recv_hold = 400;
    run_random(270);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
